/* rtl/core/assert_macros.svh */
// Assertion macros shared by the parser core modules.
// Depends on nothing; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked at every rising edge out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/ntrp_pkg.sv */
// Types and constants of the NDEF text record parser core.
// Used by the front, queue, back and top level; no dependencies.
package ntrp_pkg;

  // Defaults for top-level parameters
  localparam int COMMAND_BYTES_DEF = 16;
  localparam int MAX_RECORDS_DEF   = 4;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Record header bits and codes
  localparam logic [7:0] HDR_FLAG_MASK      = 8'h2f;
  localparam logic [7:0] HDR_TNF_WELL_KNOWN = 8'h01;
  localparam int         HDR_MB_BIT         = 7;
  localparam int         HDR_ME_BIT         = 6;
  localparam int         HDR_SR_BIT         = 4;

  // Field codes of a Text record
  localparam logic [7:0]  TYPE_LEN_ONE     = 8'h01;
  localparam logic [7:0]  UTF8_STATUS      = 8'h02;
  localparam logic [7:0]  CHAR_UPPER_T     = 8'h54;
  localparam logic [7:0]  CHAR_LOWER_D     = 8'h64;
  localparam logic [7:0]  CHAR_LOWER_T     = 8'h74;
  localparam logic [15:0] TEXT_HEAD_BYTES  = 16'd3;
  localparam logic [2:0]  LONG_LEN_BYTES   = 3'd4;

  // Result kinds
  localparam logic KIND_CMD    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MSG   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_INVALID   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_LEN_HI,
    PH_LEN_LO,
    PH_HDR,
    PH_TLEN,
    PH_PLEN,
    PH_TYPE,
    PH_STAT,
    PH_LANG1,
    PH_LANG2,
    PH_PAYLOAD,
    PH_DONE,
    PH_BAD
  } phase_t;

  // One queue entry: the results caused by one input beat
  typedef struct packed {
    logic        has_cmd;
    logic [7:0]  cmd_byte;
    logic [11:0] cmd_index;
    logic        has_stat;
    status_t     status;
  } q_entry_t;

endpackage

/* rtl/core/ntrp_ifs.sv */
// Valid/ready channel interfaces for the parser input and results.
// Depends on nothing; payload widths follow the channel fields.
interface ntrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_last;
  modport source (output valid, data_byte, buffer_last, input ready);
  modport sink (input valid, data_byte, buffer_last, output ready);
endinterface

interface ntrp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  command_byte;
  logic [11:0] command_index;
  logic [1:0]  status;
  modport source (output valid, kind, command_byte, command_index, status, input ready);
  modport sink (input valid, kind, command_byte, command_index, status, output ready);
endinterface

/* rtl/core/ntrp_front.sv */
// Front of the parser: accepts tag file bytes and walks the NDEF records.
// Depends on ntrp_pkg and ntrp_in_if; pushes result entries into the queue.
module ntrp_front #(
  parameter int COMMAND_BYTES = ntrp_pkg::COMMAND_BYTES_DEF,
  parameter int MAX_RECORDS   = ntrp_pkg::MAX_RECORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  ntrp_in_if.sink            in_ch,
  input  logic               q_full,
  output logic               push,
  output ntrp_pkg::q_entry_t entry
);

  localparam int          CntW          = $clog2(MAX_RECORDS + 1);
  localparam logic [15:0] CmdPayloadLen = 16'(COMMAND_BYTES + 3);

  ntrp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       msg_hi_r, msg_hi_nxt;
  logic [15:0]      bytes_left_r, bytes_left_nxt;
  logic [CntW-1:0]  rec_cnt_r, rec_cnt_nxt;
  logic             sr_r, sr_nxt;
  logic             me_r, me_nxt;
  logic [15:0]      plen_r, plen_nxt;
  logic             plen_hi_r, plen_hi_nxt;
  logic [2:0]       plen_cnt_r, plen_cnt_nxt;
  logic [15:0]      offset_r, offset_nxt;
  logic             is_cmd_r, is_cmd_nxt;
  logic             found_r, found_nxt;

  logic             acc;
  logic [7:0]       b;
  logic [15:0]      bl_dec;
  logic [15:0]      msg_len;
  logic [16:0]      offset_inc;
  logic [15:0]      cmd_pos;
  logic             lang_cmd;
  logic             emit_cmd;
  ntrp_pkg::phase_t fin_phase;
  ntrp_pkg::status_t st;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && !q_full;
  assign b           = in_ch.data_byte;
  assign bl_dec      = bytes_left_r - 16'd1;
  assign msg_len     = {msg_hi_r, b};
  assign offset_inc  = {1'b0, offset_r} + 17'd1;
  assign cmd_pos     = offset_r - ntrp_pkg::TEXT_HEAD_BYTES;
  assign lang_cmd    = is_cmd_r && (b == ntrp_pkg::CHAR_LOWER_T);

  // End of record: ME must sit exactly on the record that closes the message
  always_comb begin
    if (me_r != (bytes_left_r == 16'd0)) begin
      fin_phase = ntrp_pkg::PH_BAD;
    end else if (bytes_left_r == 16'd0) begin
      fin_phase = ntrp_pkg::PH_DONE;
    end else begin
      fin_phase = ntrp_pkg::PH_HDR;
    end
  end

  // Next state of the record walker
  always_comb begin
    phase_nxt      = phase_r;
    msg_hi_nxt     = msg_hi_r;
    bytes_left_nxt = bytes_left_r;
    rec_cnt_nxt    = rec_cnt_r;
    sr_nxt         = sr_r;
    me_nxt         = me_r;
    plen_nxt       = plen_r;
    plen_hi_nxt    = plen_hi_r;
    plen_cnt_nxt   = plen_cnt_r;
    offset_nxt     = offset_r;
    is_cmd_nxt     = is_cmd_r;
    found_nxt      = found_r;
    emit_cmd       = 1'b0;
    st             = ntrp_pkg::ST_BAD_MSG;
    if (acc) begin
      unique case (phase_r)
        ntrp_pkg::PH_LEN_HI: begin
          msg_hi_nxt = b;
          phase_nxt  = ntrp_pkg::PH_LEN_LO;
        end
        ntrp_pkg::PH_LEN_LO: begin
          bytes_left_nxt = msg_len;
          phase_nxt = (msg_len == 16'd0) ? ntrp_pkg::PH_BAD : ntrp_pkg::PH_HDR;
        end
        ntrp_pkg::PH_HDR: begin
          if (rec_cnt_r >= CntW'(MAX_RECORDS) ||
              bytes_left_r < ntrp_pkg::TEXT_HEAD_BYTES) begin
            phase_nxt = ntrp_pkg::PH_BAD;
          end else begin
            rec_cnt_nxt = rec_cnt_r + CntW'(1);
            sr_nxt      = b[ntrp_pkg::HDR_SR_BIT];
            me_nxt      = b[ntrp_pkg::HDR_ME_BIT];
            if ((b & ntrp_pkg::HDR_FLAG_MASK) != ntrp_pkg::HDR_TNF_WELL_KNOWN ||
                b[ntrp_pkg::HDR_MB_BIT] != (rec_cnt_r == '0)) begin
              phase_nxt = ntrp_pkg::PH_BAD;
            end else begin
              bytes_left_nxt = bl_dec;
              phase_nxt = (bl_dec == 16'd0) ? ntrp_pkg::PH_BAD : ntrp_pkg::PH_TLEN;
            end
          end
        end
        ntrp_pkg::PH_TLEN: begin
          if (b != ntrp_pkg::TYPE_LEN_ONE) begin
            phase_nxt = ntrp_pkg::PH_BAD;
          end else begin
            bytes_left_nxt = bl_dec;
            plen_nxt       = 16'd0;
            plen_hi_nxt    = 1'b0;
            plen_cnt_nxt   = 3'd0;
            phase_nxt = (bl_dec == 16'd0) ? ntrp_pkg::PH_BAD : ntrp_pkg::PH_PLEN;
          end
        end
        ntrp_pkg::PH_PLEN: begin
          // shift in one length byte; upper half only matters as non-zero
          plen_nxt       = {plen_r[7:0], b};
          plen_hi_nxt    = plen_hi_r | (plen_r[15:8] != 8'd0);
          plen_cnt_nxt   = plen_cnt_r + 3'd1;
          bytes_left_nxt = bl_dec;
          if (bl_dec == 16'd0) begin
            phase_nxt = ntrp_pkg::PH_BAD;
          end else if (sr_r || plen_cnt_nxt == ntrp_pkg::LONG_LEN_BYTES) begin
            phase_nxt = ntrp_pkg::PH_TYPE;
          end
        end
        ntrp_pkg::PH_TYPE: begin
          bytes_left_nxt = bl_dec;
          if (b != ntrp_pkg::CHAR_UPPER_T || plen_hi_r || plen_r > bl_dec ||
              plen_r < ntrp_pkg::TEXT_HEAD_BYTES) begin
            phase_nxt = ntrp_pkg::PH_BAD;
          end else begin
            bytes_left_nxt = bl_dec - plen_r;
            phase_nxt      = ntrp_pkg::PH_STAT;
          end
        end
        ntrp_pkg::PH_STAT: begin
          phase_nxt = (b != ntrp_pkg::UTF8_STATUS) ? ntrp_pkg::PH_BAD : ntrp_pkg::PH_LANG1;
        end
        ntrp_pkg::PH_LANG1: begin
          is_cmd_nxt = (b == ntrp_pkg::CHAR_LOWER_D);
          phase_nxt  = ntrp_pkg::PH_LANG2;
        end
        ntrp_pkg::PH_LANG2: begin
          is_cmd_nxt = lang_cmd;
          offset_nxt = ntrp_pkg::TEXT_HEAD_BYTES;
          if (lang_cmd && (found_r || plen_hi_r || plen_r != CmdPayloadLen)) begin
            phase_nxt = ntrp_pkg::PH_BAD;
          end else begin
            if (lang_cmd) begin
              found_nxt = 1'b1;
            end
            phase_nxt = (plen_r == ntrp_pkg::TEXT_HEAD_BYTES) ? fin_phase
                                                              : ntrp_pkg::PH_PAYLOAD;
          end
        end
        ntrp_pkg::PH_PAYLOAD: begin
          emit_cmd   = is_cmd_r;
          offset_nxt = offset_inc[15:0];
          if (offset_inc >= {1'b0, plen_r}) begin
            phase_nxt = fin_phase;
          end
        end
        default: begin
          // verdict known: drop bytes until the buffer ends
        end
      endcase

      // Close the buffer: report the verdict and start over
      if (in_ch.buffer_last) begin
        if (phase_nxt == ntrp_pkg::PH_DONE) begin
          st = found_nxt ? ntrp_pkg::ST_OK : ntrp_pkg::ST_NOT_FOUND;
        end else if (phase_nxt == ntrp_pkg::PH_LEN_LO) begin
          st = ntrp_pkg::ST_INVALID;
        end else begin
          st = ntrp_pkg::ST_BAD_MSG;
        end
        phase_nxt      = ntrp_pkg::PH_LEN_HI;
        msg_hi_nxt     = 8'd0;
        bytes_left_nxt = 16'd0;
        rec_cnt_nxt    = '0;
        sr_nxt         = 1'b0;
        me_nxt         = 1'b0;
        plen_nxt       = 16'd0;
        plen_hi_nxt    = 1'b0;
        plen_cnt_nxt   = 3'd0;
        offset_nxt     = 16'd0;
        is_cmd_nxt     = 1'b0;
        found_nxt      = 1'b0;
      end
    end
  end

  // Hand the results of this beat to the queue
  assign push            = acc && (emit_cmd || in_ch.buffer_last);
  assign entry.has_cmd   = emit_cmd;
  assign entry.cmd_byte  = b;
  assign entry.cmd_index = cmd_pos[11:0];
  assign entry.has_stat  = in_ch.buffer_last;
  assign entry.status    = st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ntrp_pkg::PH_LEN_HI;
      msg_hi_r     <= 8'd0;
      bytes_left_r <= 16'd0;
      rec_cnt_r    <= '0;
      sr_r         <= 1'b0;
      me_r         <= 1'b0;
      plen_r       <= 16'd0;
      plen_hi_r    <= 1'b0;
      plen_cnt_r   <= 3'd0;
      offset_r     <= 16'd0;
      is_cmd_r     <= 1'b0;
      found_r      <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      msg_hi_r     <= msg_hi_nxt;
      bytes_left_r <= bytes_left_nxt;
      rec_cnt_r    <= rec_cnt_nxt;
      sr_r         <= sr_nxt;
      me_r         <= me_nxt;
      plen_r       <= plen_nxt;
      plen_hi_r    <= plen_hi_nxt;
      plen_cnt_r   <= plen_cnt_nxt;
      offset_r     <= offset_nxt;
      is_cmd_r     <= is_cmd_nxt;
      found_r      <= found_nxt;
    end
  end

endmodule

/* rtl/core/ntrp_queue.sv */
// Short queue of result entries between the parser front and back.
// Depends on ntrp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ntrp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ntrp_pkg::q_entry_t wr_entry,
  input  logic               pop,
  output ntrp_pkg::q_entry_t head,
  output logic               empty,
  output logic               full
);

  localparam int Depth = ntrp_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  ntrp_pkg::q_entry_t slot_r [Depth];
  logic [PtrW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]    count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CntW'(Depth));
  assign head  = slot_r[rd_ptr_r];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold entry storage; written on push only
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_entry;
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !full)
  `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, !empty)
  `ASSERT_NEXT(a_count_holds, clk, rst_n, !push && !pop, $stable(count_r))

endmodule

/* rtl/core/ntrp_back.sv */
// Back of the parser: drains queue entries into the result channel.
// Depends on ntrp_pkg, ntrp_out_if and assert_macros.svh.
`include "assert_macros.svh"
module ntrp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ntrp_pkg::q_entry_t head,
  input  logic               q_empty,
  output logic               pop,
  ntrp_out_if.source         out_ch
);

  ntrp_pkg::q_entry_t cur_r, cur_nxt;
  logic               cur_valid_r, cur_valid_nxt;
  logic               take;
  logic               entry_done;

  assign take       = cur_valid_r && out_ch.ready;
  // An entry with both a command byte and a status takes two beats
  assign entry_done = !(cur_r.has_cmd && cur_r.has_stat);
  assign pop        = (!cur_valid_r || (take && entry_done)) && !q_empty;

  // Advance the output register
  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    if (take && !entry_done) begin
      cur_nxt.has_cmd = 1'b0;
    end else if (!cur_valid_r || take) begin
      cur_nxt       = head;
      cur_valid_nxt = !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // Drive the result beat; unused fields read as zero
  assign out_ch.valid         = cur_valid_r;
  assign out_ch.kind          = cur_r.has_cmd ? ntrp_pkg::KIND_CMD : ntrp_pkg::KIND_STATUS;
  assign out_ch.command_byte  = cur_r.has_cmd ? cur_r.cmd_byte : 8'd0;
  assign out_ch.command_index = cur_r.has_cmd ? cur_r.cmd_index : 12'd0;
  assign out_ch.status        = cur_r.has_cmd ? ntrp_pkg::ST_OK : cur_r.status;

  `ASSERT_NEXT(a_split_pair, clk, rst_n, take && !entry_done, cur_valid_r && !cur_r.has_cmd && cur_r.has_stat)
  `ASSERT_IMPLIES(a_status_zero_fields, clk, rst_n, cur_valid_r && !cur_r.has_cmd, out_ch.command_byte == 8'd0 && out_ch.command_index == 12'd0)
  `ASSERT_IMPLIES(a_no_pop_while_held, clk, rst_n, cur_valid_r && !out_ch.ready, !pop)

endmodule

/* rtl/core/ndef_text_record_parser_core.sv */
// NDEF Text record parser core.
// in_ch takes the tag file one byte per beat, buffer_last set on the final
// byte of the buffer. The first two bytes give the big-endian message length;
// up to MAX_RECORDS Text records follow. The payload bytes of the "dt" record
// leave on out_ch as command beats (kind 0, command_byte, command_index), and
// the beat with buffer_last closes the buffer with one status beat (kind 1):
// 0 ok, 1 bad message, 2 command not found, 3 invalid buffer.
// Throughput: one input byte per cycle while the queue is not full; a byte
// that yields both a command beat and the status beat sends them one after
// the other. A result passes through the result queue and then the output
// register before it appears on out_ch.
// When out_ch stalls, results gather in the four-entry queue and the output
// register; in_ch.ready drops only once the queue is full.
// Synchronous active-low reset clears the parser to expect the first length
// byte and empties the queue and output register; no clearing pass is needed.
// Files: ntrp_pkg, ntrp_ifs, ntrp_front, ntrp_queue, ntrp_back.
module ndef_text_record_parser_core #(
  parameter int COMMAND_BYTES = ntrp_pkg::COMMAND_BYTES_DEF,
  parameter int MAX_RECORDS   = ntrp_pkg::MAX_RECORDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ntrp_in_if.sink    in_ch,
  ntrp_out_if.source out_ch
);

  ntrp_pkg::q_entry_t wr_entry;
  ntrp_pkg::q_entry_t head;
  logic               push;
  logic               pop;
  logic               q_empty;
  logic               q_full;

  // Parse and classify incoming bytes
  ntrp_front #(
    .COMMAND_BYTES (COMMAND_BYTES),
    .MAX_RECORDS   (MAX_RECORDS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .entry  (wr_entry)
  );

  // Decouple front from back
  ntrp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Emit result beats
  ntrp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
